[design/clmf_pkg.sv]
// ----------------------------------------------------------------------------
// Cluster local maximum finder package
// Shared constants, command and hit types, and the back end state encoding.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package clmf_pkg;

  localparam int unsigned DetectorsDef     = 4096;
  localparam int unsigned NeighboursMaxDef = 8;
  localparam int unsigned ClusterMaxDef    = 64;

  localparam int unsigned IdW     = 12;
  localparam int unsigned SlotW   = 3;
  localparam int unsigned IdxW    = 16;
  localparam int unsigned EnergyW = 24;
  localparam int unsigned NbW     = IdW + 1;

  typedef enum logic [1:0] {
    OP_NOP,
    OP_TBL,
    OP_HIT
  } op_e;

  typedef struct packed {
    op_e                op;
    logic [IdW-1:0]     det;
    logic [SlotW-1:0]   slot;
    logic [IdW-1:0]     nid;
    logic               nvalid;
    logic [IdxW-1:0]    idx;
    logic [EnergyW-1:0] energy;
    logic               cend;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_chan_t;

  typedef struct packed {
    logic [IdxW-1:0]    idx;
    logic [IdW-1:0]     det;
    logic [EnergyW-1:0] energy;
  } hit_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOAD,
    ST_LWAIT,
    ST_NB,
    ST_SCAN,
    ST_DRAIN,
    ST_EMIT
  } state_e;

endpackage

[design/cluster_local_maximum_finder_top.sv]
// ----------------------------------------------------------------------------
// Cluster local maximum finder
// Buffers the hits of a cluster and flags the local energy maxima.
// ----------------------------------------------------------------------------
//  Channel  Signals                       Beat
//  in       in_valid_i / in_stall_o       table slot write or cluster hit
//  out      out_valid_o / out_stall_i     one evaluated hit
//  cfg      cfg_valid_i / cfg_ready_o     energy threshold
//
//  After reset the neighbour table is cleared one slot a cycle, and no input
//  beat is taken meanwhile. The back end takes a table write or a hit without
//  cluster end while idle. At cluster end each of the n buffered hits is loaded,
//  its neighbour slots are read from the table in turn and all n hits are scanned
//  before it is emitted, as the table and hit buffer RAMs have single read ports.
//  A two-entry queue decouples input stalls from output stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cluster_local_maximum_finder_top #(
  parameter int unsigned DETECTORS      = clmf_pkg::DetectorsDef,
  parameter int unsigned NEIGHBOURS_MAX = clmf_pkg::NeighboursMaxDef,
  parameter int unsigned CLUSTER_MAX    = clmf_pkg::ClusterMaxDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         kind_i,
  input  logic [clmf_pkg::IdW-1:0]     detector_id_i,
  input  logic [clmf_pkg::SlotW-1:0]   neighbour_slot_i,
  input  logic [clmf_pkg::IdW-1:0]     neighbour_id_i,
  input  logic                         neighbour_valid_i,
  input  logic [clmf_pkg::IdxW-1:0]    hit_index_i,
  input  logic [clmf_pkg::EnergyW-1:0] energy_i,
  input  logic                         cluster_end_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [clmf_pkg::IdxW-1:0]    out_hit_index_o,
  output logic [clmf_pkg::IdW-1:0]     out_detector_id_o,
  output logic                         is_maximum_o,
  output logic                         cluster_overflow_o,
  output logic                         run_last_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [clmf_pkg::EnergyW-1:0] cfg_data_i
);

  import clmf_pkg::*;

  logic [EnergyW-1:0] thr_q;
  cmd_chan_t          cmd;
  logic               pop, clearing;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      thr_q <= cfg_data_i;
    end
  end

  clmf_front #(.Detectors(DETECTORS), .NeighboursMax(NEIGHBOURS_MAX)) u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .kind_i            (kind_i),
    .detector_id_i     (detector_id_i),
    .neighbour_slot_i  (neighbour_slot_i),
    .neighbour_id_i    (neighbour_id_i),
    .neighbour_valid_i (neighbour_valid_i),
    .hit_index_i       (hit_index_i),
    .energy_i          (energy_i),
    .cluster_end_i     (cluster_end_i),
    .clearing_i        (clearing),
    .cmd_o             (cmd),
    .pop_i             (pop)
  );

  clmf_back #(
    .Detectors     (DETECTORS),
    .NeighboursMax (NEIGHBOURS_MAX),
    .ClusterMax    (CLUSTER_MAX)
  ) u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .pop_o              (pop),
    .clearing_o         (clearing),
    .threshold_i        (thr_q),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .out_hit_index_o    (out_hit_index_o),
    .out_detector_id_o  (out_detector_id_o),
    .is_maximum_o       (is_maximum_o),
    .cluster_overflow_o (cluster_overflow_o),
    .run_last_o         (run_last_o)
  );

endmodule

[design/clmf_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module clmf_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

[design/clmf_front.sv]
// ----------------------------------------------------------------------------
// Front end
// Accepts input beats, classifies them into commands and queues them.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module clmf_front #(
  parameter int unsigned Detectors     = clmf_pkg::DetectorsDef,
  parameter int unsigned NeighboursMax = clmf_pkg::NeighboursMaxDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         kind_i,
  input  logic [clmf_pkg::IdW-1:0]     detector_id_i,
  input  logic [clmf_pkg::SlotW-1:0]   neighbour_slot_i,
  input  logic [clmf_pkg::IdW-1:0]     neighbour_id_i,
  input  logic                         neighbour_valid_i,
  input  logic [clmf_pkg::IdxW-1:0]    hit_index_i,
  input  logic [clmf_pkg::EnergyW-1:0] energy_i,
  input  logic                         cluster_end_i,
  input  logic                         clearing_i,
  output clmf_pkg::cmd_chan_t          cmd_o,
  input  logic                         pop_i
);

  import clmf_pkg::*;

  cmd_t       fifo_q [2];
  logic       wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push;
  cmd_t       cmd_new;

  always_comb begin
    cmd_new.det    = detector_id_i;
    cmd_new.slot   = neighbour_slot_i;
    cmd_new.nid    = neighbour_id_i;
    cmd_new.nvalid = neighbour_valid_i;
    cmd_new.idx    = hit_index_i;
    cmd_new.energy = energy_i;
    cmd_new.cend   = cluster_end_i;
    if (kind_i) begin
      cmd_new.op = OP_HIT;
    end else if ((32'(detector_id_i) < Detectors) && (32'(neighbour_slot_i) < NeighboursMax)) begin
      cmd_new.op = OP_TBL;
    end else begin
      cmd_new.op = OP_NOP;
    end
  end

  assign in_stall_o = (cnt_q == 2'd2) || clearing_i;
  assign push       = in_valid_i && !in_stall_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = !wr_ptr_q;
    end
    if (pop_i) begin
      rd_ptr_d = !rd_ptr_q;
    end
    if (push && !pop_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (!push && pop_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= cmd_new;
    end
  end

  assign cmd_o.valid = (cnt_q != 2'd0);
  assign cmd_o.cmd   = fifo_q[rd_ptr_q];

endmodule

[design/clmf_back.sv]
// ----------------------------------------------------------------------------
// Back end
// Clears and writes the neighbour table, buffers hits and evaluates clusters.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module clmf_back #(
  parameter int unsigned Detectors     = clmf_pkg::DetectorsDef,
  parameter int unsigned NeighboursMax = clmf_pkg::NeighboursMaxDef,
  parameter int unsigned ClusterMax    = clmf_pkg::ClusterMaxDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  clmf_pkg::cmd_chan_t          cmd_i,
  output logic                         pop_o,
  output logic                         clearing_o,
  input  logic [clmf_pkg::EnergyW-1:0] threshold_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [clmf_pkg::IdxW-1:0]    out_hit_index_o,
  output logic [clmf_pkg::IdW-1:0]     out_detector_id_o,
  output logic                         is_maximum_o,
  output logic                         cluster_overflow_o,
  output logic                         run_last_o
);

  import clmf_pkg::*;

  localparam int unsigned TDepth = Detectors * NeighboursMax;
  localparam int unsigned TAW    = $clog2(TDepth);
  localparam int unsigned HAW    = $clog2(ClusterMax);
  localparam int unsigned CW     = HAW + 1;
  localparam int unsigned SW     = $clog2(NeighboursMax);
  localparam int unsigned HitW   = $bits(hit_t);

  state_e state_q, state_d;
  logic [TAW-1:0] clr_q, clr_d;
  logic [CW-1:0]  cnt_q, cnt_d, n_q, n_d;
  logic           ovf_q, ovf_d;
  logic [HAW-1:0] k_q, k_d, j_q, j_d;
  logic [SW-1:0]  s_q, s_d, nb_slot_q;
  hit_t           h_q, h_d;
  logic           known_q, known_d, kill_q, kill_d;
  logic           nb_pend_q, nb_pend_d, sc_pend_q, sc_pend_d;
  logic [NeighboursMax-1:0]          nbv_q;
  logic [NeighboursMax-1:0][IdW-1:0] nbid_q;

  logic              t_we, t_re;
  logic [TAW-1:0]    t_waddr, t_raddr;
  logic [NbW-1:0]    t_wdata, t_rdata;
  logic              h_we, h_re;
  logic [HAW-1:0]    h_waddr, h_raddr;
  hit_t              h_wdata;
  logic [HitW-1:0]   h_rdata_raw;
  hit_t              h_rdata;
  logic              listed, k_last, out_free, load_out;
  logic [CW-1:0]     cnt_post;

  logic              out_valid_q, out_valid_d;
  logic [IdxW-1:0]   out_idx_q;
  logic [IdW-1:0]    out_det_q;
  logic              out_max_q, out_ovf_q, out_last_q;

  assign h_rdata = hit_t'(h_rdata_raw);

  clmf_ram #(.Width(NbW), .Depth(TDepth)) u_table (
    .clk_i   (clk_i),
    .we_i    (t_we),
    .waddr_i (t_waddr),
    .wdata_i (t_wdata),
    .re_i    (t_re),
    .raddr_i (t_raddr),
    .rdata_o (t_rdata)
  );

  clmf_ram #(.Width(HitW), .Depth(ClusterMax)) u_hits (
    .clk_i   (clk_i),
    .we_i    (h_we),
    .waddr_i (h_waddr),
    .wdata_i (h_wdata),
    .re_i    (h_re),
    .raddr_i (h_raddr),
    .rdata_o (h_rdata_raw)
  );

  always_comb begin
    listed = 1'b0;
    for (int unsigned s = 0; s < NeighboursMax; s++) begin
      if (nbv_q[s] && (nbid_q[s] == h_rdata.det)) begin
        listed = 1'b1;
      end
    end
    listed = listed && known_q;
  end

  assign k_last   = (({1'b0, k_q}) + CW'(1)) == n_q;
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d   = state_q;
    clr_d     = clr_q;
    cnt_d     = cnt_q;
    n_d       = n_q;
    ovf_d     = ovf_q;
    k_d       = k_q;
    j_d       = j_q;
    s_d       = s_q;
    h_d       = h_q;
    known_d   = known_q;
    kill_d    = kill_q;
    nb_pend_d = 1'b0;
    sc_pend_d = 1'b0;
    pop_o     = 1'b0;
    load_out  = 1'b0;
    cnt_post  = cnt_q;
    t_we      = 1'b0;
    t_waddr   = TAW'((32'(cmd_i.cmd.det) * NeighboursMax) + 32'(cmd_i.cmd.slot));
    t_wdata   = cmd_i.cmd.nvalid ? {1'b1, cmd_i.cmd.nid} : '0;
    t_re      = 1'b0;
    t_raddr   = TAW'((32'(h_q.det) * NeighboursMax) + 32'(s_q));
    h_we      = 1'b0;
    h_waddr   = cnt_q[HAW-1:0];
    h_wdata   = '{idx: cmd_i.cmd.idx, det: cmd_i.cmd.det, energy: cmd_i.cmd.energy};
    h_re      = 1'b0;
    h_raddr   = k_q;

    if (sc_pend_q && listed && (h_rdata.det != h_q.det) && (h_rdata.energy > h_q.energy)) begin
      kill_d = 1'b1;
    end

    unique case (state_q)
      ST_CLEAR: begin
        t_we    = 1'b1;
        t_waddr = clr_q;
        t_wdata = '0;
        clr_d   = clr_q + TAW'(1);
        if (clr_q == TAW'(TDepth - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (cmd_i.valid) begin
          pop_o = 1'b1;
          case (cmd_i.cmd.op)
            OP_TBL: t_we = 1'b1;
            OP_HIT: begin
              if (cnt_q < CW'(ClusterMax)) begin
                h_we     = 1'b1;
                cnt_post = cnt_q + CW'(1);
              end else begin
                ovf_d = 1'b1;
              end
              cnt_d = cnt_post;
              if (cmd_i.cmd.cend) begin
                n_d     = cnt_post;
                k_d     = '0;
                state_d = ST_LOAD;
              end
            end
            default: ;
          endcase
        end
      end
      ST_LOAD: begin
        h_re    = 1'b1;
        h_raddr = k_q;
        state_d = ST_LWAIT;
      end
      ST_LWAIT: begin
        h_d     = h_rdata;
        known_d = 32'(h_rdata.det) < Detectors;
        kill_d  = 1'b0;
        s_d     = '0;
        state_d = ST_NB;
      end
      ST_NB: begin
        t_re      = 1'b1;
        nb_pend_d = 1'b1;
        s_d       = s_q + SW'(1);
        if (32'(s_q) == NeighboursMax - 1) begin
          j_d     = '0;
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        h_re      = 1'b1;
        h_raddr   = j_q;
        sc_pend_d = 1'b1;
        j_d       = j_q + HAW'(1);
        if (({1'b0, j_q} + CW'(1)) == n_q) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          load_out = 1'b1;
          if (k_last) begin
            cnt_d   = '0;
            ovf_d   = 1'b0;
            state_d = ST_IDLE;
          end else begin
            k_d     = k_q + HAW'(1);
            state_d = ST_LOAD;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase

    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      cnt_q       <= '0;
      ovf_q       <= 1'b0;
      nb_pend_q   <= 1'b0;
      sc_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      cnt_q       <= cnt_d;
      ovf_q       <= ovf_d;
      nb_pend_q   <= nb_pend_d;
      sc_pend_q   <= sc_pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q       <= n_d;
    k_q       <= k_d;
    j_q       <= j_d;
    s_q       <= s_d;
    h_q       <= h_d;
    known_q   <= known_d;
    kill_q    <= kill_d;
    nb_slot_q <= s_q;
    if (nb_pend_q) begin
      nbv_q[nb_slot_q]  <= t_rdata[NbW-1];
      nbid_q[nb_slot_q] <= t_rdata[IdW-1:0];
    end
    if (load_out) begin
      out_idx_q  <= h_q.idx;
      out_det_q  <= h_q.det;
      out_max_q  <= (h_q.energy >= threshold_i) && !kill_q;
      out_ovf_q  <= ovf_q;
      out_last_q <= k_last;
    end
  end

  assign clearing_o         = (state_q == ST_CLEAR);
  assign out_valid_o        = out_valid_q;
  assign out_hit_index_o    = out_idx_q;
  assign out_detector_id_o  = out_det_q;
  assign is_maximum_o       = out_max_q;
  assign cluster_overflow_o = out_ovf_q;
  assign run_last_o         = out_last_q;

endmodule
